[rtl/gsm7_pkg.sv]
package gsm7_pkg;

  // Field and state widths.
  localparam int SeptetW = 7;
  localparam int OctetW  = 8;
  localparam int CfgW    = 8;
  localparam int AccW    = 2 * SeptetW;
  localparam int HeldW   = 3;
  localparam int PosW    = 9;

  // The septet position stops counting here.
  localparam logic [PosW-1:0] PosMax = 9'd511;

  // Depth of the queue between the front and back parts.
  localparam int QueueDepth = 2;

  // Configuration register indexes.
  typedef enum logic {
    RegSkip  = 1'b0,
    RegCount = 1'b1
  } reg_index_t;

  // One classified septet: its code, the last mark and whether it is emitted.
  typedef struct packed {
    logic [SeptetW-1:0] code;
    logic               last;
    logic               valid;
  } septet_t;

  // Everything one octet yields, in emission order: s0 first, then s1.
  typedef struct packed {
    septet_t s1;
    septet_t s0;
  } pair_t;

  // Handshake between the queue and the back part.
  typedef struct packed {
    logic  not_empty;
    pair_t head;
  } queue_head_t;

endpackage

[rtl/gsm7_septet_unpacker.sv]
// GSM 7-bit septet unpacker.
// The input channel (in_valid, in_stall, octet, first_octet) takes packed user
// data one octet per beat; first_octet set starts a new message. The output
// channel (out_valid, out_stall, septet, last_septet) gives the 7-bit codes in
// stream order, with last_septet on the final septet of the configured count.
// Registers over the APB port: skip_septets at address 0 and septet_count at
// address 4; write them only while the block is idle.
// A septet is registered in a queue slot, the current entry and the output.
// An octet yields zero, one or two septets; the single output register sets
// the pace at one septet per cycle while out_stall is low, so two septets of
// one octet leave in turn; zero-septet octets are absorbed in the front part.
// A two-entry queue separates the front and back parts. in_stall rises when
// the queue is full: when the receiver holds out_stall, or when a steady
// stream of octets brings more than one septet per cycle, as every seventh
// octet of a message yields two. A stalled result holds steady until taken.
// Reset clears the registers, the bit accumulator, the position and the queue.
module gsm7_septet_unpacker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [gsm7_pkg::OctetW-1:0]  octet,
  input  logic                         first_octet,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsm7_pkg::SeptetW-1:0] septet,
  output logic                         last_septet,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  logic [gsm7_pkg::CfgW-1:0] skip_septets;
  logic [gsm7_pkg::CfgW-1:0] septet_count;
  gsm7_pkg::reg_index_t      reg_sel;
  logic                      cfg_write;

  gsm7_pkg::pair_t           entry;
  gsm7_pkg::queue_head_t     head;
  logic                      push;
  logic                      pop;
  logic                      queue_full;

  // Register file.
  assign pready    = 1'b1;
  assign reg_sel   = gsm7_pkg::reg_index_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_septets <= '0;
      septet_count <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        gsm7_pkg::RegSkip:  skip_septets <= pwdata[gsm7_pkg::CfgW-1:0];
        gsm7_pkg::RegCount: septet_count <= pwdata[gsm7_pkg::CfgW-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      gsm7_pkg::RegSkip:  prdata = {{(32-gsm7_pkg::CfgW){1'b0}}, skip_septets};
      gsm7_pkg::RegCount: prdata = {{(32-gsm7_pkg::CfgW){1'b0}}, septet_count};
    endcase
  end

  gsm7_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .octet        (octet),
    .first_octet  (first_octet),
    .skip_septets (skip_septets),
    .septet_count (septet_count),
    .queue_full   (queue_full),
    .push         (push),
    .entry        (entry)
  );

  gsm7_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_entry (entry),
    .full     (queue_full),
    .pop      (pop),
    .head     (head)
  );

  gsm7_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .septet      (septet),
    .last_septet (last_septet)
  );

endmodule

[rtl/gsm7_front.sv]
module gsm7_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [gsm7_pkg::OctetW-1:0]     octet,
  input  logic                            first_octet,
  input  logic [gsm7_pkg::CfgW-1:0]       skip_septets,
  input  logic [gsm7_pkg::CfgW-1:0]       septet_count,
  input  logic                            queue_full,
  output logic                            push,
  output gsm7_pkg::pair_t                 entry
);

  // Classify one septet position against the current window.
  function automatic gsm7_pkg::septet_t classify(
    input logic [gsm7_pkg::PosW-1:0]    pos,
    input logic [gsm7_pkg::CfgW-1:0]    skip,
    input logic [gsm7_pkg::CfgW-1:0]    cnt,
    input logic [gsm7_pkg::SeptetW-1:0] code
  );
    logic [gsm7_pkg::PosW-1:0] idx;
    logic [gsm7_pkg::PosW-1:0] skip_w;
    logic [gsm7_pkg::PosW-1:0] cnt_w;
    gsm7_pkg::septet_t         s;
    skip_w  = {1'b0, skip};
    cnt_w   = {1'b0, cnt};
    idx     = pos - skip_w;
    s.code  = code;
    s.valid = (pos >= skip_w) && (idx < cnt_w);
    s.last  = (idx == cnt_w - {{(gsm7_pkg::PosW-1){1'b0}}, 1'b1});
    return s;
  endfunction

  // Position counter that stops at its top value.
  function automatic logic [gsm7_pkg::PosW-1:0] pos_inc(input logic [gsm7_pkg::PosW-1:0] p);
    return (p == gsm7_pkg::PosMax) ? p : p + {{(gsm7_pkg::PosW-1){1'b0}}, 1'b1};
  endfunction

  logic [gsm7_pkg::AccW-1:0]  acc;
  logic [gsm7_pkg::AccW-1:0]  acc_next;
  logic [gsm7_pkg::HeldW-1:0] held;
  logic [gsm7_pkg::HeldW-1:0] held_next;
  logic [gsm7_pkg::PosW-1:0]  pos;
  logic [gsm7_pkg::PosW-1:0]  pos_next;

  logic [gsm7_pkg::AccW-1:0]  acc_eff;
  logic [gsm7_pkg::HeldW-1:0] held_eff;
  logic [gsm7_pkg::PosW-1:0]  pos_eff;
  logic [gsm7_pkg::PosW-1:0]  pos1;
  logic [gsm7_pkg::AccW-1:0]  merged;
  logic                       two;
  logic                       accept;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;

  // Merge the new octet above the bits still held; a first octet starts afresh.
  always_comb begin
    acc_eff  = first_octet ? '0 : acc;
    held_eff = first_octet ? '0 : held;
    pos_eff  = first_octet ? '0 : pos;
    merged   = acc_eff | ({{(gsm7_pkg::AccW-gsm7_pkg::OctetW){1'b0}}, octet} << held_eff);
    // Six held bits plus eight new ones make two whole septets.
    two      = (held_eff == 3'd6);
    pos1     = pos_inc(pos_eff);

    entry.s0 = classify(pos_eff, skip_septets, septet_count,
                        merged[gsm7_pkg::SeptetW-1:0]);
    entry.s1 = classify(pos1, skip_septets, septet_count,
                        merged[gsm7_pkg::AccW-1:gsm7_pkg::SeptetW]);
    entry.s1.valid = entry.s1.valid && two;

    if (two) begin
      acc_next  = '0;
      held_next = '0;
      pos_next  = pos_inc(pos1);
    end else begin
      acc_next  = {{gsm7_pkg::SeptetW{1'b0}}, merged[gsm7_pkg::AccW-1:gsm7_pkg::SeptetW]};
      held_next = held_eff + 3'd1;
      pos_next  = pos1;
    end

    // Octets that yield nothing emitted are absorbed here.
    push = accept && (entry.s0.valid || entry.s1.valid);
  end

  // Unpacking state.
  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      held <= '0;
      pos  <= '0;
    end else if (accept) begin
      acc  <= acc_next;
      held <= held_next;
      pos  <= pos_next;
    end
  end

endmodule

[rtl/gsm7_queue.sv]
module gsm7_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  gsm7_pkg::pair_t       wr_entry,
  output logic                  full,
  input  logic                  pop,
  output gsm7_pkg::queue_head_t head
);

  localparam int PtrW = (gsm7_pkg::QueueDepth > 1) ? $clog2(gsm7_pkg::QueueDepth) : 1;
  localparam int CntW = $clog2(gsm7_pkg::QueueDepth + 1);
  localparam logic [CntW-1:0] Depth = CntW'(gsm7_pkg::QueueDepth);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(gsm7_pkg::QueueDepth - 1);

  gsm7_pkg::pair_t slots [gsm7_pkg::QueueDepth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] fill;
  logic            do_push;
  logic            do_pop;

  assign full           = (fill == Depth);
  assign head.not_empty = (fill != '0);
  assign head.head      = slots[rd_ptr];
  assign do_push        = push && !full;
  assign do_pop         = pop && head.not_empty;

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_entry;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CntW'(1);
      end
    end
  end

endmodule

[rtl/gsm7_back.sv]
module gsm7_back (
  input  logic                         clk,
  input  logic                         rst,
  input  gsm7_pkg::queue_head_t        head,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [gsm7_pkg::SeptetW-1:0] septet,
  output logic                         last_septet
);

  gsm7_pkg::pair_t   cur;
  gsm7_pkg::pair_t   rem;
  gsm7_pkg::septet_t pick;
  logic              have;
  logic              out_free;
  logic              emit;
  logic              rem_empty;

  assign out_free = !out_valid || !out_stall;
  assign have     = cur.s0.valid || cur.s1.valid;
  assign emit     = out_free && have;

  // Pick the earliest pending septet and work out what is left afterwards.
  always_comb begin
    rem = cur;
    if (cur.s0.valid) begin
      pick         = cur.s0;
      rem.s0.valid = 1'b0;
    end else begin
      pick         = cur.s1;
      rem.s1.valid = 1'b0;
    end
    rem_empty = !(rem.s0.valid || rem.s1.valid);
    // Refill as the last pending septet leaves, so there is no bubble.
    pop       = head.not_empty && (!have || (emit && rem_empty));
  end

  // Current entry being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      cur <= '0;
    end else if (pop) begin
      cur <= head.head;
    end else if (emit) begin
      cur <= rem;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      septet      <= pick.code;
      last_septet <= pick.last;
    end
  end

endmodule
